// ----- hw/rtl/sorted_list_insert_remove_top_assert.svh -----
// ----------------------------------------------------------------------------
// sorted list assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list check failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list check failed");

`else

`define SLI_ASSERT_NOW(lbl, ante, cons)
`define SLI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// shared constants, codes and types of the sorted list
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int DEPTH   = 16;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// command broadcast to every cell
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage

// ----- hw/rtl/sorted_list_insert_remove_top.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// sorted list priority queue: insert in order, remove one equal entry
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   value[31:0]                                 opcode[0]
//  m_axis   out  status[1:0] count[6:2] smallest[38:7] 0s    -
//
// one transaction per cycle while m_axis does not stall: every cell compares against the broadcast value
// and shifts in the same cycle, so the list is updated at the accepting edge
// the result is registered, appears in the cycle after acceptance and holds while m_axis stalls
// s_axis_tready is high when the result register is empty or being taken
// reset clears the slot valid bits and the count; no clearing pass is needed
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value[31:0]
	input  logic [0:0]  s_axis_tuser,   // opcode[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // status[1:0] count[6:2] smallest[38:7]
);

	`include "sorted_list_insert_remove_top_assert.svh"

	logic                        accept;
	logic                        is_insert;
	sli_pkg::cmd_t               cmd;
	logic                        full;
	logic                        found;
	logic                        head_valid;
	logic [sli_pkg::VAL_W-1:0]   head_val;
	logic [sli_pkg::DEPTH-1:0]   valid_vec;
	logic [sli_pkg::CNT_W-1:0]   count_q;
	sli_pkg::status_t            status_d;
	sli_pkg::status_t            status_q;
	logic                        out_valid_q;
	logic [sli_pkg::VAL_W-1:0]   smallest;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_insert     = (sli_pkg::op_t'(s_axis_tuser) == sli_pkg::OP_INSERT);

	assign cmd.ins_en = accept && is_insert && !full;
	assign cmd.rem_en = accept && !is_insert && found;
	assign cmd.value  = s_axis_tdata;

	sli_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.full       (full),
		.found      (found),
		.head_valid (head_valid),
		.head_val   (head_val),
		.valid_vec  (valid_vec)
	);

	always_comb begin
		priority if (is_insert && full) begin
			status_d = sli_pkg::ST_FULL;
		end else if (!is_insert && !found) begin
			status_d = sli_pkg::ST_NOT_FOUND;
		end else begin
			status_d = sli_pkg::ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_en) begin
				count_q <= count_q + sli_pkg::CNT_W'(1);
			end else if (cmd.rem_en) begin
				count_q <= count_q - sli_pkg::CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// list state only moves on accept, so it matches the pending result
	assign smallest = head_valid ? head_val : '0;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, smallest,
		sli_pkg::COUNT_W'(count_q), status_q};

	`SLI_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_vec) == int'(count_q))
	`SLI_ASSERT_NOW(a_count_in_range, 1'b1, int'(count_q) <= sli_pkg::DEPTH)
	`SLI_ASSERT_NEXT(a_full_insert_keeps, accept && is_insert && full, $stable(count_q))
	`SLI_ASSERT_NEXT(a_remove_miss_keeps, accept && !is_insert && !found, $stable(valid_vec))
	`SLI_ASSERT_NEXT(a_stall_holds_status, m_axis_tvalid && !m_axis_tready, $stable(status_q))

endmodule

// ----- hw/rtl/sli_cell.sv -----
// ----------------------------------------------------------------------------
// sli_cell
// one slot of the sorted list: compares against the broadcast value and
// shifts toward its left or right neighbor
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sli_pkg::cmd_t              cmd,
	input  logic                       left_lt,
	input  logic                       left_valid,
	input  logic [sli_pkg::VAL_W-1:0]  left_val,
	input  logic                       right_valid,
	input  logic [sli_pkg::VAL_W-1:0]  right_val,
	output logic                       lt,
	output logic                       hit,
	output logic                       valid,
	output logic [sli_pkg::VAL_W-1:0]  val
);

	logic                      valid_q;
	logic [sli_pkg::VAL_W-1:0] val_q;

	assign lt    = valid_q && ($signed(val_q) < $signed(cmd.value));
	// first slot not below the value, and only if it equals the value
	assign hit   = valid_q && !lt && left_lt && (val_q == cmd.value);
	assign valid = valid_q;
	assign val   = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins_en && !lt) begin
			valid_q <= valid_q || left_valid;
		end else if (cmd.rem_en && !lt) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt) begin
			val_q <= left_lt ? cmd.value : left_val;
		end else if (cmd.rem_en && !lt) begin
			val_q <= right_val;
		end
	end

endmodule

// ----- hw/rtl/sli_chain.sv -----
// ----------------------------------------------------------------------------
// sli_chain
// row of cells holding the list in ascending order, slot zero the smallest
// ----------------------------------------------------------------------------
module sli_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sli_pkg::cmd_t              cmd,
	output logic                       full,
	output logic                       found,
	output logic                       head_valid,
	output logic [sli_pkg::VAL_W-1:0]  head_val,
	output logic [sli_pkg::DEPTH-1:0]  valid_vec
);

	logic [sli_pkg::DEPTH-1:0] lt_vec;
	logic [sli_pkg::DEPTH-1:0] hit_vec;
	logic [sli_pkg::VAL_W-1:0] val_arr [sli_pkg::DEPTH];

	for (genvar i = 0; i < sli_pkg::DEPTH; i++) begin : g_cell
		logic                      l_lt;
		logic                      l_valid;
		logic [sli_pkg::VAL_W-1:0] l_val;
		logic                      r_valid;
		logic [sli_pkg::VAL_W-1:0] r_val;

		if (i == 0) begin : g_first
			// head cell sees an always-smaller, always-valid left edge
			assign l_lt    = 1'b1;
			assign l_valid = 1'b1;
			assign l_val   = '0;
		end else begin : g_mid
			assign l_lt    = lt_vec[i-1];
			assign l_valid = valid_vec[i-1];
			assign l_val   = val_arr[i-1];
		end

		if (i == sli_pkg::DEPTH - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_val   = '0;
		end else begin : g_inner
			assign r_valid = valid_vec[i+1];
			assign r_val   = val_arr[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_lt     (l_lt),
			.left_valid  (l_valid),
			.left_val    (l_val),
			.right_valid (r_valid),
			.right_val   (r_val),
			.lt          (lt_vec[i]),
			.hit         (hit_vec[i]),
			.valid       (valid_vec[i]),
			.val         (val_arr[i])
		);
	end

	assign full       = valid_vec[sli_pkg::DEPTH-1];
	assign found      = |hit_vec;
	assign head_valid = valid_vec[0];
	assign head_val   = val_arr[0];

endmodule
